// ----- rtl/ras_pkg.sv -----
// ----------------------------------------------------------------------------
// Rational approximation search package
// Widths, configuration register indexes and the microcode program of the
// mediant search sequencer.
// ----------------------------------------------------------------------------
package ras_pkg;

  // Field and datapath widths.
  localparam int unsigned ValueW = 64;
  localparam int unsigned FracW  = 32;
  localparam int unsigned NumW   = 32;
  localparam int unsigned DenW   = 31;
  localparam int unsigned ErrW   = 32;
  localparam int unsigned StepsW = 16;
  localparam int unsigned ProdW  = ErrW + DenW;
  localparam int unsigned AccW   = 94;
  localparam int unsigned DiffW  = 96;
  localparam int unsigned PcW    = 3;

  // Configuration register indexes.
  localparam logic CfgMaxError  = 1'b0;
  localparam logic CfgIterLimit = 1'b1;

  // Register values after reset.
  localparam logic [ErrW-1:0]   MaxErrorReset  = 32'd429497;
  localparam logic [StepsW-1:0] IterLimitReset = 16'd20000;

  // Program addresses.
  localparam logic [PcW-1:0] PcIdle = 3'd0;
  localparam logic [PcW-1:0] PcMed  = 3'd1;
  localparam logic [PcW-1:0] PcMlo  = 3'd2;
  localparam logic [PcW-1:0] PcMhi  = 3'd3;
  localparam logic [PcW-1:0] PcMerr = 3'd4;
  localparam logic [PcW-1:0] PcTest = 3'd5;
  localparam logic [PcW-1:0] PcLoop = 3'd6;
  localparam logic [PcW-1:0] PcFail = 3'd7;

  // Datapath operation of one step.
  typedef enum logic [2:0] {
    OP_IDLE,
    OP_MED,
    OP_MLO,
    OP_MHI,
    OP_MERR,
    OP_TEST,
    OP_NONE,
    OP_FAIL
  } op_e;

  // Jump condition of one step; a false condition falls through to the next.
  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_ALWAYS,
    JMP_WAIT,
    JMP_OVF,
    JMP_HIT,
    JMP_MORE
  } jmp_e;

  typedef struct packed {
    op_e            op;
    jmp_e           jmp;
    logic [PcW-1:0] target;
  } ucode_t;

  // Microcode program of the search.
  function automatic ucode_t ucode_rom(input logic [PcW-1:0] pc);
    ucode_t uc;
    case (pc)
      PcIdle:  uc = '{op: OP_IDLE, jmp: JMP_WAIT,   target: PcIdle};
      PcMed:   uc = '{op: OP_MED,  jmp: JMP_OVF,    target: PcFail};
      PcMlo:   uc = '{op: OP_MLO,  jmp: JMP_NEXT,   target: PcIdle};
      PcMhi:   uc = '{op: OP_MHI,  jmp: JMP_NEXT,   target: PcIdle};
      PcMerr:  uc = '{op: OP_MERR, jmp: JMP_NEXT,   target: PcIdle};
      PcTest:  uc = '{op: OP_TEST, jmp: JMP_HIT,    target: PcIdle};
      PcLoop:  uc = '{op: OP_NONE, jmp: JMP_MORE,   target: PcMed};
      PcFail:  uc = '{op: OP_FAIL, jmp: JMP_ALWAYS, target: PcIdle};
      default: uc = '{op: OP_FAIL, jmp: JMP_ALWAYS, target: PcIdle};
    endcase
    return uc;
  endfunction

endpackage

// ----- rtl/rational_approximation_search.sv -----
// ----------------------------------------------------------------------------
// Rational approximation search
// Finds a fraction num/den close to a signed Q31.32 value by a mediant walk.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising edge with start high and busy low; it
//   carries target_value_i. One result follows for every request: done_o is
//   high for exactly one cycle with frac_numerator_o, frac_denominator_o and
//   found_o. The receiver cannot stall; the result must be taken that cycle.
//   An integer value, a ceiling out of range or an iteration limit of zero
//   answers in the cycle after the request. Otherwise the block walks
//   mediants: each mediant step runs the microcode steps MED, MLO, MHI,
//   MERR, TEST and LOOP, and the shared 32 x 31 multiplier is used three
//   times per step, in MLO, MHI and MERR. A hit in TEST answers with the
//   mediant; a mediant overflow, or a search that runs out of steps, ends
//   in FAIL with found_o low. busy is high while a search runs; a new
//   request may be made while done_o is high. Configuration writes
//   (cfg_we_i, cfg_index_i, cfg_data_i) take effect at once; the user makes
//   them only while busy is low, which the block itself does not enforce.
//   Reset returns the registers to their defaults and the sequencer to idle.
// ----------------------------------------------------------------------------
module rational_approximation_search (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [ras_pkg::ValueW-1:0]   target_value_i,
  output logic                                done_o,
  output logic signed [ras_pkg::NumW-1:0]     frac_numerator_o,
  output logic        [ras_pkg::DenW-1:0]     frac_denominator_o,
  output logic                                found_o,
  input  logic                                cfg_we_i,
  input  logic                                cfg_index_i,
  input  logic        [ras_pkg::ErrW-1:0]     cfg_data_i
);

  // Sequencer and configuration.
  logic [ras_pkg::PcW-1:0]    pc_q, pc_d;
  logic [ras_pkg::ErrW-1:0]   err_limit_q;
  logic [ras_pkg::StepsW-1:0] iter_limit_q;
  ras_pkg::ucode_t            uc;

  // Search state.
  logic signed [ras_pkg::NumW-1:0] low_num_q, low_num_d, high_num_q, high_num_d;
  logic [ras_pkg::DenW-1:0]        low_den_q, low_den_d, high_den_q, high_den_d;
  logic [ras_pkg::StepsW-1:0]      steps_q, steps_d;
  logic signed [ras_pkg::NumW-1:0] mn_q, mn_d;
  logic [ras_pkg::DenW-1:0]        md_q, md_d;
  logic                            vneg_q, vneg_d;
  logic [ras_pkg::ValueW-1:0]      vmag_q, vmag_d;
  logic [ras_pkg::AccW-1:0]        acc_q, acc_d;
  logic [ras_pkg::ProdW-1:0]       lim_q, lim_d;
  logic [ras_pkg::DiffW-1:0]       diff_q, diff_d;

  // Result registers.
  logic                            done_q, done_d;
  logic signed [ras_pkg::NumW-1:0] num_q, num_d;
  logic [ras_pkg::DenW-1:0]        den_q, den_d;
  logic                            found_q, found_d;

  // Request decode.
  logic                            accept;
  logic signed [ras_pkg::NumW-1:0] floor_v;
  logic                            frac_nz;
  logic                            ceil_ovf;
  logic                            launch;

  // Datapath intermediates.
  logic [ras_pkg::NumW:0]        sum_n;
  logic [ras_pkg::DenW:0]        sum_d;
  logic                          ovf;
  logic [ras_pkg::ErrW-1:0]      mul_a;
  logic [ras_pkg::ProdW-1:0]     prod;
  logic [ras_pkg::DiffW-1:0]     mn_wide;
  logic [ras_pkg::DiffW-1:0]     acc_wide;
  logic [ras_pkg::DiffW-1:0]     diff_plus_lim;
  logic                          diff_neg;
  logic                          hit;
  logic                          cond;

  assign uc     = ras_pkg::ucode_rom(pc_q);
  assign busy   = (pc_q != ras_pkg::PcIdle);
  assign accept = start && !busy;

  // The floor is the integer part; the ceiling leaves range only above the top.
  assign floor_v  = target_value_i[ras_pkg::ValueW-1:ras_pkg::FracW];
  assign frac_nz  = (target_value_i[ras_pkg::FracW-1:0] != '0);
  assign ceil_ovf = frac_nz && (floor_v == {1'b0, {(ras_pkg::NumW-1){1'b1}}});
  assign launch   = accept && frac_nz && !ceil_ovf && (iter_limit_q != '0);

  // Mediant sums and their overflow test.
  assign sum_n = {low_num_q[ras_pkg::NumW-1], low_num_q}
               + {high_num_q[ras_pkg::NumW-1], high_num_q};
  assign sum_d = {1'b0, low_den_q} + {1'b0, high_den_q};
  assign ovf   = (sum_n[ras_pkg::NumW] != sum_n[ras_pkg::NumW-1]) || sum_d[ras_pkg::DenW];

  // The one multiplier, shared by the three product steps.
  always_comb begin
    case (uc.op)
      ras_pkg::OP_MLO: mul_a = vmag_q[ras_pkg::FracW-1:0];
      ras_pkg::OP_MHI: mul_a = vmag_q[ras_pkg::ValueW-1:ras_pkg::FracW];
      default:         mul_a = err_limit_q;
    endcase
  end
  assign prod = {{ras_pkg::DenW{1'b0}}, mul_a} * {{ras_pkg::ErrW{1'b0}}, md_q};

  // Signed error num * 2^32 - value * den, and the exact limit test.
  assign mn_wide  = {{(ras_pkg::DiffW - ras_pkg::NumW - ras_pkg::FracW){mn_q[ras_pkg::NumW-1]}},
                     mn_q, {ras_pkg::FracW{1'b0}}};
  assign acc_wide = {{(ras_pkg::DiffW - ras_pkg::AccW){1'b0}}, acc_q};
  assign diff_neg      = diff_q[ras_pkg::DiffW-1];
  assign diff_plus_lim = diff_q + {{(ras_pkg::DiffW - ras_pkg::ProdW){1'b0}}, lim_q};
  assign hit = diff_neg ? !diff_plus_lim[ras_pkg::DiffW-1]
                        : (diff_q <= {{(ras_pkg::DiffW - ras_pkg::ProdW){1'b0}}, lim_q});

  // Jump condition of the current step.
  always_comb begin
    case (uc.jmp)
      ras_pkg::JMP_ALWAYS: cond = 1'b1;
      ras_pkg::JMP_WAIT:   cond = !launch;
      ras_pkg::JMP_OVF:    cond = ovf;
      ras_pkg::JMP_HIT:    cond = hit;
      ras_pkg::JMP_MORE:   cond = (steps_q != '0);
      default:             cond = 1'b0;
    endcase
  end
  assign pc_d = cond ? uc.target : pc_q + 1'b1;

  // Datapath actions of each step.
  always_comb begin
    low_num_d  = low_num_q;
    low_den_d  = low_den_q;
    high_num_d = high_num_q;
    high_den_d = high_den_q;
    steps_d    = steps_q;
    mn_d       = mn_q;
    md_d       = md_q;
    vneg_d     = vneg_q;
    vmag_d     = vmag_q;
    acc_d      = acc_q;
    lim_d      = lim_q;
    diff_d     = diff_q;
    done_d     = 1'b0;
    num_d      = num_q;
    den_d      = den_q;
    found_d    = found_q;
    case (uc.op)
      ras_pkg::OP_IDLE: begin
        if (accept) begin
          if (ceil_ovf || (frac_nz && iter_limit_q == '0)) begin
            done_d  = 1'b1;
            num_d   = '0;
            den_d   = '0;
            found_d = 1'b0;
          end else if (!frac_nz) begin
            done_d  = 1'b1;
            num_d   = floor_v;
            den_d   = {{(ras_pkg::DenW-1){1'b0}}, 1'b1};
            found_d = 1'b1;
          end
        end
        if (launch) begin
          low_num_d  = floor_v;
          high_num_d = floor_v + 1'b1;
          low_den_d  = {{(ras_pkg::DenW-1){1'b0}}, 1'b1};
          high_den_d = {{(ras_pkg::DenW-1){1'b0}}, 1'b1};
          steps_d    = iter_limit_q;
          vneg_d     = target_value_i[ras_pkg::ValueW-1];
          vmag_d     = target_value_i[ras_pkg::ValueW-1] ? (~target_value_i + 1'b1)
                                                         : target_value_i;
        end
      end
      ras_pkg::OP_MED: begin
        mn_d = sum_n[ras_pkg::NumW-1:0];
        md_d = sum_d[ras_pkg::DenW-1:0];
      end
      ras_pkg::OP_MLO: begin
        acc_d = {{(ras_pkg::AccW - ras_pkg::ProdW){1'b0}}, prod};
      end
      ras_pkg::OP_MHI: begin
        acc_d = acc_q + {prod[ras_pkg::AccW-ras_pkg::FracW-1:0], {ras_pkg::FracW{1'b0}}};
      end
      ras_pkg::OP_MERR: begin
        lim_d  = prod;
        diff_d = vneg_q ? (mn_wide + acc_wide) : (mn_wide - acc_wide);
      end
      ras_pkg::OP_TEST: begin
        if (hit) begin
          done_d  = 1'b1;
          num_d   = mn_q;
          den_d   = md_q;
          found_d = 1'b1;
        end else begin
          steps_d = steps_q - 1'b1;
          if (diff_neg) begin
            low_num_d = mn_q;
            low_den_d = md_q;
          end else begin
            high_num_d = mn_q;
            high_den_d = md_q;
          end
        end
      end
      ras_pkg::OP_FAIL: begin
        done_d  = 1'b1;
        num_d   = '0;
        den_d   = '0;
        found_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Control registers and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q         <= ras_pkg::PcIdle;
      done_q       <= 1'b0;
      steps_q      <= '0;
      err_limit_q  <= ras_pkg::MaxErrorReset;
      iter_limit_q <= ras_pkg::IterLimitReset;
    end else begin
      pc_q    <= pc_d;
      done_q  <= done_d;
      steps_q <= steps_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          ras_pkg::CfgMaxError:  err_limit_q  <= cfg_data_i;
          ras_pkg::CfgIterLimit: iter_limit_q <= cfg_data_i[ras_pkg::StepsW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    low_num_d_reg: begin
      low_num_q  <= low_num_d;
      low_den_q  <= low_den_d;
      high_num_q <= high_num_d;
      high_den_q <= high_den_d;
      mn_q       <= mn_d;
      md_q       <= md_d;
      vneg_q     <= vneg_d;
      vmag_q     <= vmag_d;
      acc_q      <= acc_d;
      lim_q      <= lim_d;
      diff_q     <= diff_d;
      num_q      <= num_d;
      den_q      <= den_d;
      found_q    <= found_d;
    end
  end

  assign done_o             = done_q;
  assign frac_numerator_o   = num_q;
  assign frac_denominator_o = den_q;
  assign found_o            = found_q;

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational approximation search testbench
// Drives signed Q31.32 requests into the mediant search block, predicts each
// fraction with an independent cycle-free model of the walk, and compares
// every result field by field. The register settings change between phases,
// with the block idle, and the sender idles in random bursts.
// ----------------------------------------------------------------------------
module tb;

  // One predicted or observed answer.
  typedef struct {
    logic signed [ras_pkg::NumW-1:0] num;
    logic [ras_pkg::DenW-1:0]        den;
    logic                            found;
  } fraction_t;

  // Entries of the stimulus plan.
  typedef enum logic [1:0] {
    STIM_VALUE,
    STIM_WRITE,
    STIM_SETTLE
  } stim_kind_e;

  typedef struct {
    stim_kind_e                  kind;
    logic [ras_pkg::ValueW-1:0]  value;
    logic                        index;
    logic [ras_pkg::ErrW-1:0]    data;
  } stim_t;

  localparam longint IntMax = 64'sd2147483647;
  localparam longint IntMin = -IntMax - 1;
  localparam int unsigned DrainLimit = 6 * 65536 + 64;
  localparam int unsigned CalmItems = 12;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              start = 1'b0;
  logic                              busy;
  logic signed [ras_pkg::ValueW-1:0] target_value_i = '0;
  logic                              done_o;
  logic signed [ras_pkg::NumW-1:0]   frac_numerator_o;
  logic [ras_pkg::DenW-1:0]          frac_denominator_o;
  logic                              found_o;
  logic                              cfg_we_i = 1'b0;
  logic                              cfg_index_i = 1'b0;
  logic [ras_pkg::ErrW-1:0]          cfg_data_i = '0;

  // Copy of the registers and of the search bounds.
  logic [ras_pkg::ErrW-1:0]   err_limit = ras_pkg::MaxErrorReset;
  logic [ras_pkg::StepsW-1:0] step_limit = ras_pkg::IterLimitReset;
  longint                     lower_num = 0;
  longint                     lower_den = 0;
  longint                     upper_num = 0;
  longint                     upper_den = 0;
  int unsigned                steps_left = 0;

  stim_t       plan_q[$];
  fraction_t   fraction_queue[$];
  int unsigned value_count = 0;
  int unsigned sent_count = 0;
  int unsigned calm_start = 0;
  int unsigned idle_left = 0;
  int unsigned write_count = 0;
  int unsigned found_count = 0;
  int unsigned invalid_count = 0;
  int unsigned fail_count = 0;

  rational_approximation_search uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .target_value_i     (target_value_i),
    .done_o             (done_o),
    .frac_numerator_o   (frac_numerator_o),
    .frac_denominator_o (frac_denominator_o),
    .found_o            (found_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Exact error test: |num * 2^32 - value * den| <= error limit * den.
  // value_above is set when the value lies above num/den.
  function automatic bit within_error(logic signed [ras_pkg::ValueW-1:0] value, longint num,
                                      longint den, output bit value_above);
    logic signed [127:0] scaled;
    logic signed [127:0] product;
    logic signed [127:0] gap;
    logic signed [127:0] allowed;
    scaled = num;
    scaled = scaled <<< ras_pkg::FracW;
    product = value;
    product = product * den;
    gap = scaled - product;
    value_above = gap < 0;
    if (value_above) gap = -gap;
    allowed = {96'd0, err_limit};
    allowed = allowed * den;
    return gap <= allowed;
  endfunction

  // Mediant walk between floor/1 and ceiling/1 of the value.
  function automatic fraction_t approximate(logic signed [ras_pkg::ValueW-1:0] value);
    fraction_t res;
    longint    fl;
    longint    ce;
    longint    mid_num;
    longint    mid_den;
    bit        above;
    res = '{num: '0, den: '0, found: 1'b0};
    fl = value >>> ras_pkg::FracW;
    ce = fl + ((value[ras_pkg::FracW-1:0] != '0) ? 1 : 0);
    if (fl < IntMin || fl > IntMax || ce < IntMin || ce > IntMax) return res;
    if (fl == ce) begin
      res.num = fl[ras_pkg::NumW-1:0];
      res.den = {{(ras_pkg::DenW-1){1'b0}}, 1'b1};
      res.found = 1'b1;
      return res;
    end
    lower_num = fl;
    lower_den = 1;
    upper_num = ce;
    upper_den = 1;
    steps_left = {16'd0, step_limit};
    while (steps_left > 0) begin
      steps_left--;
      mid_num = lower_num + upper_num;
      mid_den = lower_den + upper_den;
      // A sum leaving the 32-bit signed range ends the search.
      if (mid_num > IntMax || mid_num < IntMin || mid_den > IntMax) return res;
      if (within_error(value, mid_num, mid_den, above)) begin
        res.num = mid_num[ras_pkg::NumW-1:0];
        res.den = mid_den[ras_pkg::DenW-1:0];
        res.found = 1'b1;
        return res;
      end
      if (above) begin
        lower_num = mid_num;
        lower_den = mid_den;
      end else begin
        upper_num = mid_num;
        upper_den = mid_den;
      end
    end
    return res;
  endfunction

  // Random values: mostly small values with real searches, plus integers,
  // near-integers, simple rationals, wide magnitudes and the top floor.
  function automatic logic [ras_pkg::ValueW-1:0] random_value();
    logic [ras_pkg::ValueW-1:0] v;
    logic [31:0]                frac;
    longint                     p;
    longint                     q;
    int                         ip;
    case ($urandom_range(0, 9))
      0: v = {$urandom, $urandom};
      1: v = {$urandom, 32'h0};
      2: v = {32'h7FFF_FFFF, $urandom | 32'h1};
      3: begin
        ip = int'($urandom_range(0, 31)) - 16;
        frac = $urandom_range(1, 4095);
        if ($urandom_range(0, 1) == 1) frac = -frac;
        v = {ip, frac};
      end
      4: begin
        q = longint'($urandom_range(1, 60));
        p = longint'($urandom_range(0, 400)) - 200;
        v = (p <<< ras_pkg::FracW) / q;
      end
      5: begin
        ip = int'($urandom >> $urandom_range(0, 31));
        if ($urandom_range(0, 1) == 1) ip = -ip;
        v = {ip, $urandom};
      end
      default: begin
        ip = int'($urandom_range(0, 31)) - 16;
        v = {ip, $urandom};
      end
    endcase
    return v;
  endfunction

  task automatic add_value(logic [ras_pkg::ValueW-1:0] value);
    plan_q.push_back('{kind: STIM_VALUE, value: value, index: 1'b0, data: '0});
    value_count++;
  endtask

  // Every register write waits until the block has delivered all results.
  task automatic add_write(logic index, logic [ras_pkg::ErrW-1:0] data);
    plan_q.push_back('{kind: STIM_SETTLE, value: '0, index: 1'b0, data: '0});
    plan_q.push_back('{kind: STIM_WRITE, value: '0, index: index, data: data});
  endtask

  // Request driver, fed from the plan queue.
  always @(posedge clk_i or negedge rst_ni) begin
    bit next_start;
    bit next_we;
    if (!rst_ni) begin
      start <= 1'b0;
      cfg_we_i <= 1'b0;
    end else begin
      next_start = start;
      next_we = 1'b0;
      if (start && !busy) begin
        fraction_queue.push_back(approximate(target_value_i));
        sent_count++;
        next_start = 1'b0;
        if (sent_count < calm_start && $urandom_range(0, 2) == 0)
          idle_left = $urandom_range(1, 16);
      end
      if (!next_start && idle_left > 0) begin
        idle_left--;
      end else if (!next_start && plan_q.size() != 0) begin
        case (plan_q[0].kind)
          STIM_VALUE: begin
            target_value_i <= plan_q[0].value;
            next_start = 1'b1;
            void'(plan_q.pop_front());
          end
          STIM_WRITE: begin
            cfg_index_i <= plan_q[0].index;
            cfg_data_i <= plan_q[0].data;
            next_we = 1'b1;
            if (plan_q[0].index == ras_pkg::CfgMaxError) err_limit = plan_q[0].data;
            else step_limit = plan_q[0].data[ras_pkg::StepsW-1:0];
            write_count++;
            void'(plan_q.pop_front());
          end
          STIM_SETTLE: begin
            // Checked with done_o low so the monitor cannot pop this edge.
            if (!busy && !done_o && fraction_queue.size() == 0)
              void'(plan_q.pop_front());
          end
          default: void'(plan_q.pop_front());
        endcase
      end
      start <= next_start;
      cfg_we_i <= next_we;
    end
  end

  // Result monitor: every strobe is checked against the oldest prediction.
  always @(posedge clk_i) begin
    fraction_t want;
    if (rst_ni && done_o) begin
      if (fraction_queue.size() == 0) begin
        $display("%0t: unexpected result %0d/%0d found %0b", $time, frac_numerator_o,
                 frac_denominator_o, found_o);
        fail_count++;
      end else begin
        want = fraction_queue.pop_front();
        if (frac_numerator_o !== want.num) begin
          $display("%0t: numerator expected %0d, got %0d", $time, want.num,
                   frac_numerator_o);
          fail_count++;
        end
        if (frac_denominator_o !== want.den) begin
          $display("%0t: denominator expected %0d, got %0d", $time, want.den,
                   frac_denominator_o);
          fail_count++;
        end
        if (found_o !== want.found) begin
          $display("%0t: found expected %0b, got %0b", $time, want.found, found_o);
          fail_count++;
        end
      end
      if (found_o) found_count++;
      else invalid_count++;
    end
  end

  initial begin
    int unsigned waited;
    // Reset settings: integers, the range limits, mediant overflow both
    // ways, and one long walk toward a value just below zero.
    add_value(64'h0000_0000_0000_0000);
    add_value(64'h0000_0001_0000_0000);
    add_value(64'hFFFF_FFFF_0000_0000);
    add_value(64'h7FFF_FFFF_FFFF_FFFF);
    add_value(64'h8000_0000_0000_0000);
    add_value(64'h7FFF_FFFF_0000_0000);
    add_value(64'h0000_0000_8000_0000);
    add_value(64'hFFFF_FFFF_8000_0000);
    add_value(64'h0000_0003_243F_6A89);
    add_value(64'h4000_0000_8000_0000);
    add_value(64'hBFFF_FFFF_8000_0000);
    add_value(64'hFFFF_FFFF_FFFF_FFFF);
    // No steps allowed: only integers succeed.
    add_write(ras_pkg::CfgMaxError, 32'h0);
    add_write(ras_pkg::CfgIterLimit, 32'hA5A5_0000);
    add_value(64'h0000_0000_8000_0000);
    add_value(64'h0000_0003_0000_0000);
    add_value(64'h8000_0000_0000_0001);
    // Zero error: an exact hit, a walk that runs out and an overflow.
    add_write(ras_pkg::CfgIterLimit, 32'h5A5A_00C8);
    add_value(64'h0000_0000_5555_5555);
    add_value(64'h0000_0000_C000_0000);
    add_value(64'h0000_0000_9E37_79B9);
    add_value(64'h8000_0000_0000_0001);
    // Widest error and the largest step count: the first mediant passes.
    add_write(ras_pkg::CfgMaxError, 32'hFFFF_FFFF);
    add_write(ras_pkg::CfgIterLimit, 32'hFFFF_FFFF);
    add_value(64'h0000_0002_4000_0000);
    add_value(64'h3FFF_FFFF_8000_0000);
    add_value(64'h1234_5678_9ABC_DEF0);
    // Random phases, each with its own error and step limit.
    for (int ph = 0; ph < 6; ph++) begin
      add_write(ras_pkg::CfgMaxError, $urandom >> $urandom_range(0, 31));
      if (ph == 0)
        add_write(ras_pkg::CfgIterLimit, {16'($urandom), 16'($urandom_range(0, 3))});
      else
        add_write(ras_pkg::CfgIterLimit, {16'($urandom), 16'($urandom_range(4, 300))});
      for (int k = 0; k < 13; k++) add_value(random_value());
    end
    calm_start = value_count - CalmItems;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (plan_q.size() != 0 || start) @(negedge clk_i);
    waited = 0;
    while (fraction_queue.size() != 0 && waited < DrainLimit) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (16) @(negedge clk_i);
    if (fraction_queue.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, fraction_queue.size());
      fail_count++;
    end

    $display("Sent %0d requests across %0d register writes.", sent_count, write_count);
    $display("Results: %0d fractions found, %0d invalid answers.", found_count,
             invalid_count);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #36_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
